// File: rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define PTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition never seen at a clock edge outside reset.
`define PTS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/ptsu_pkg.sv
// Shared types and codes of the process table scheduler.
package ptsu_pkg;

    localparam logic [2:0] CMD_SPAWN = 3'd0;
    localparam logic [2:0] CMD_INIT  = 3'd1;
    localparam logic [2:0] CMD_YIELD = 3'd2;
    localparam logic [2:0] CMD_SLEEP = 3'd3;
    localparam logic [2:0] CMD_WAKE  = 3'd4;
    localparam logic [2:0] CMD_KILL  = 3'd5;
    localparam logic [2:0] CMD_EXIT  = 3'd6;
    localparam logic [2:0] CMD_WAIT  = 3'd7;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_NOPID   = 3'd2;
    localparam logic [2:0] STAT_NOCHILD = 3'd3;
    localparam logic [2:0] STAT_BLOCKED = 3'd4;
    localparam logic [2:0] STAT_NONE    = 3'd5;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_UNINIT   = 3'd1;
    localparam logic [2:0] ST_RUNNABLE = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;
    localparam logic [2:0] ST_SLEEPING = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [31:0] OWN_CHAN_BASE = 32'h8000_0000;

    // one slot of the task table, parent link kept apart (its width follows SLOTS)
    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] pid;
        logic [31:0] chan;
        logic        killed;
        logic [31:0] exit_val;
    } rec_t;

endpackage

// File: rtl/ptsu_table.sv
// Task table memory: one write port, one registered read port.
module ptsu_table
    import ptsu_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int SW    = 6,
    parameter int PW    = 7
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [SW-1:0] waddr,
    input  rec_t          wrec,
    input  logic [PW-1:0] wpar,
    input  logic          re,
    input  logic [SW-1:0] raddr,
    output rec_t          rd_rec,
    output logic [PW-1:0] rd_par
);

    rec_t          mem_rec [SLOTS];
    logic [PW-1:0] mem_par [SLOTS];
    rec_t          rd_rec_reg;
    logic [PW-1:0] rd_par_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_rec[waddr] <= wrec;
            mem_par[waddr] <= wpar;
        end
        if (re)
        begin
            rd_rec_reg <= mem_rec[raddr];
            rd_par_reg <= mem_par[raddr];
        end
    end

    assign rd_rec = rd_rec_reg;
    assign rd_par = rd_par_reg;

endmodule

// File: rtl/process_table_scheduler_unit.sv
// Process table scheduler top: command sequencer around one slot compare/update unit.
// Passes: each command runs scan passes over the table (alloc 1 pass, kill/wake 1,
//   yield/sleep 1, wait up to 2, exit up to 3).
// Throughput: one command at a time; the table read port, one slot per cycle, sets the pace.
// Reset: a clearing pass over every slot runs first with busy high; slot 0 comes up running.
// Results show for one cycle with done high; the receiver cannot stall.
`include "assert_macros.svh"

module process_table_scheduler_unit
    import ptsu_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  command,
    input  logic [31:0] operand,
    output logic        busy,
    output logic        done,
    output logic [2:0]  result_status,
    output logic [5:0]  result_slot,
    output logic [31:0] result_pid,
    output logic [31:0] reaped_exit_code,
    output logic [5:0]  running_slot,
    output logic [31:0] running_pid,
    output logic        running_killed
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam int CW = SW + 1;
    localparam logic [PW-1:0] NONE = PW'(SLOTS);    // "no parent" / "no init"
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_RDCUR  = 8'b0000_0100,
        S_DECODE = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_CURWR  = 8'b0010_0000,
        S_RDOUT  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    // what a scan pass does to each slot
    typedef enum logic [2:0] {
        PASS_ALLOC,
        PASS_SWITCH,
        PASS_WAKE,
        PASS_KILL,
        PASS_REPAR,
        PASS_REAP
    } pass_t;

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
        return (p == LAST) ? '0 : p + SW'(1);
    endfunction

    function automatic logic [31:0] chan_of(input logic [PW-1:0] p);
        return (p < NONE) ? OWN_CHAN_BASE + 32'(p) : 32'd0;
    endfunction

    // sequencer state
    state_t        state_reg, state_next;
    pass_t         pass_reg, pass_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [31:0]   opnd_reg, opnd_next;
    logic [SW-1:0] ptr_reg, ptr_next;       // next slot to read (also clear pointer)
    logic [CW-1:0] cnt_reg, cnt_next;       // slots issued in this pass
    logic          stop_reg, stop_next;     // first-hit pass has hit
    logic          q_vld_reg, q_vld_next;   // read data in flight
    logic [SW-1:0] q_idx_reg, q_idx_next;
    logic          found_reg, found_next;
    logic          reaped_reg, reaped_next;
    logic [2:0]    sw_ok_reg, sw_ok_next;   // status a successful switch reports
    logic [31:0]   keya_reg, keya_next;
    logic [31:0]   keyb_reg, keyb_next;
    logic [PW-1:0] newpar_reg, newpar_next; // parent of the exiting task after reparenting
    rec_t          cur_rec_reg, cur_rec_next;
    logic [PW-1:0] cur_par_reg, cur_par_next;

    // architectural scalars
    logic [SW-1:0] run_reg, run_next;
    logic [PW-1:0] init_reg, init_next;
    logic [31:0]   ctr_reg, ctr_next;

    // result beat
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic [5:0]    rslot_reg, rslot_next;
    logic [31:0]   rpid_reg, rpid_next;
    logic [31:0]   rcode_reg, rcode_next;
    logic [5:0]    rrun_reg, rrun_next;
    logic [31:0]   rrun_pid_reg, rrun_pid_next;
    logic          rrun_kill_reg, rrun_kill_next;

    // table ports
    logic          tbl_we, tbl_re;
    logic [SW-1:0] waddr, raddr;
    rec_t          wrec, rd_rec;
    logic [PW-1:0] wpar, rd_par;

    // shared slot unit
    logic          m;           // slot matches the pass condition
    logic          hit_now;     // first-hit pass stops here
    logic          child;
    logic          idx_is_cur, par_is_cur;
    rec_t          u_rec;
    logic [PW-1:0] u_par;
    logic          issue_en, complete;
    logic          go_pass;
    pass_t         go_kind;
    logic          active;

    ptsu_table #(.SLOTS(SLOTS), .SW(SW), .PW(PW)) u_table (
        .clk    (clk),
        .we     (tbl_we),
        .waddr  (waddr),
        .wrec   (wrec),
        .wpar   (wpar),
        .re     (tbl_re),
        .raddr  (raddr),
        .rd_rec (rd_rec),
        .rd_par (rd_par)
    );

    // Slot compare/update unit: looks at the slot read last cycle and forms its new value.
    always_comb
    begin
        idx_is_cur = (q_idx_reg == run_reg);
        par_is_cur = (rd_par == PW'(run_reg));
        child      = (rd_rec.st != ST_UNUSED) && par_is_cur;
        m          = 1'b0;
        u_rec      = rd_rec;
        u_par      = rd_par;
        unique case (pass_reg)
            PASS_ALLOC:
            begin
                m         = (rd_rec.st == ST_UNUSED);
                u_rec     = '0;
                u_rec.st  = ST_RUNNABLE;
                u_rec.pid = ctr_reg;
                u_par     = (cmd_reg == CMD_SPAWN) ? PW'(run_reg) : NONE;
            end
            PASS_SWITCH:
            begin
                m        = (rd_rec.st == ST_RUNNABLE);
                u_rec.st = ST_RUNNING;
            end
            PASS_WAKE:
            begin
                m = (rd_rec.st == ST_SLEEPING) &&
                    ((rd_rec.chan == keya_reg) || (rd_rec.chan == keyb_reg));
                u_rec.st = ST_RUNNABLE;
            end
            PASS_KILL:
            begin
                m = ((rd_rec.st == ST_RUNNABLE) || (rd_rec.st == ST_RUNNING) ||
                     (rd_rec.st == ST_SLEEPING)) && (rd_rec.pid == opnd_reg);
                u_rec.killed = 1'b1;
                if (rd_rec.st == ST_SLEEPING)
                begin
                    u_rec.st = ST_RUNNABLE;
                end
            end
            PASS_REPAR:
            begin
                m     = child || idx_is_cur;
                u_par = child ? init_reg : rd_par;
                if (idx_is_cur)
                begin
                    u_rec.st       = ST_ZOMBIE;
                    u_rec.exit_val = opnd_reg;
                end
            end
            PASS_REAP:
            begin
                m     = child && (rd_rec.st == ST_ZOMBIE);
                u_rec = '0;
                u_par = NONE;
            end
            default:
            begin
                m = 1'b0;
            end
        endcase
        hit_now = q_vld_reg && m && ((pass_reg == PASS_ALLOC) ||
                  (pass_reg == PASS_SWITCH) || (pass_reg == PASS_REAP));
        issue_en = !stop_reg && !hit_now && (cnt_reg < CW'(SLOTS));
        complete = !q_vld_reg && !issue_en;
    end

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        cmd_next       = cmd_reg;
        opnd_next      = opnd_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        stop_next      = stop_reg;
        q_vld_next     = 1'b0;
        q_idx_next     = q_idx_reg;
        found_next     = found_reg;
        reaped_next    = reaped_reg;
        sw_ok_next     = sw_ok_reg;
        keya_next      = keya_reg;
        keyb_next      = keyb_reg;
        newpar_next    = newpar_reg;
        cur_rec_next   = cur_rec_reg;
        cur_par_next   = cur_par_reg;
        run_next       = run_reg;
        init_next      = init_reg;
        ctr_next       = ctr_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        rslot_next     = rslot_reg;
        rpid_next      = rpid_reg;
        rcode_next     = rcode_reg;
        rrun_next      = rrun_reg;
        rrun_pid_next  = rrun_pid_reg;
        rrun_kill_next = rrun_kill_reg;
        tbl_we         = 1'b0;
        tbl_re         = 1'b0;
        waddr          = ptr_reg;
        raddr          = ptr_reg;
        wrec           = '0;
        wpar           = NONE;
        go_pass        = 1'b0;
        go_kind        = PASS_SWITCH;
        active         = (rd_rec.st == ST_RUNNING);

        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_we = 1'b1;
                if (ptr_reg == '0)
                begin
                    wrec.st = ST_RUNNING;
                end
                ptr_next = wrap_inc(ptr_reg);
                if (ptr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = command;
                    opnd_next   = operand;
                    status_next = STAT_OK;
                    rslot_next  = '0;
                    rpid_next   = '0;
                    rcode_next  = '0;
                    sw_ok_next  = STAT_OK;
                    state_next  = S_RDCUR;
                end
            end
            S_RDCUR:
            begin
                tbl_re     = 1'b1;
                raddr      = run_reg;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cur_rec_next = rd_rec;
                cur_par_next = rd_par;
                waddr        = run_reg;
                wrec         = rd_rec;
                wpar         = rd_par;
                case (cmd_reg)
                    CMD_SPAWN, CMD_INIT:
                    begin
                        go_pass = 1'b1;
                        go_kind = PASS_ALLOC;
                    end
                    CMD_YIELD:
                    begin
                        tbl_we  = active;
                        wrec.st = ST_RUNNABLE;
                        go_pass = 1'b1;
                    end
                    CMD_SLEEP:
                    begin
                        tbl_we    = active;
                        wrec.st   = ST_SLEEPING;
                        wrec.chan = opnd_reg;
                        go_pass   = 1'b1;
                    end
                    CMD_WAKE:
                    begin
                        keya_next = opnd_reg;
                        keyb_next = opnd_reg;
                        go_pass   = 1'b1;
                        go_kind   = PASS_WAKE;
                    end
                    CMD_KILL:
                    begin
                        go_pass = 1'b1;
                        go_kind = PASS_KILL;
                    end
                    CMD_EXIT:
                    begin
                        if (!active)
                        begin
                            go_pass = 1'b1;
                        end
                        else if (init_reg != PW'(run_reg))
                        begin
                            go_pass = 1'b1;
                            go_kind = PASS_REPAR;
                        end
                        else
                        begin
                            // init exiting: ignored
                            state_next = S_RDOUT;
                        end
                    end
                    default:
                    begin
                        go_pass = 1'b1;
                        go_kind = active ? PASS_REAP : PASS_SWITCH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (q_vld_reg && m)
                begin
                    tbl_we = 1'b1;
                    waddr  = q_idx_reg;
                    wrec   = u_rec;
                    wpar   = u_par;
                    unique case (pass_reg)
                        PASS_ALLOC:
                        begin
                            found_next = 1'b1;
                            rslot_next = 6'(q_idx_reg);
                            rpid_next  = ctr_reg;
                            ctr_next   = ctr_reg + 32'd1;
                            if (cmd_reg == CMD_INIT)
                            begin
                                init_next = PW'(q_idx_reg);
                            end
                        end
                        PASS_SWITCH:
                        begin
                            found_next = 1'b1;
                            run_next   = q_idx_reg;
                        end
                        PASS_REAP:
                        begin
                            reaped_next = 1'b1;
                            rslot_next  = 6'(q_idx_reg);
                            rpid_next   = rd_rec.pid;
                            rcode_next  = rd_rec.exit_val;
                        end
                        PASS_REPAR:
                        begin
                            if (idx_is_cur)
                            begin
                                newpar_next = u_par;
                            end
                        end
                        default:
                        begin
                            found_next = 1'b1;
                        end
                    endcase
                end
                if (q_vld_reg && child && (pass_reg == PASS_REAP))
                begin
                    found_next = 1'b1;
                end
                stop_next = stop_reg || hit_now;
                if (issue_en)
                begin
                    tbl_re     = 1'b1;
                    raddr      = ptr_reg;
                    ptr_next   = wrap_inc(ptr_reg);
                    cnt_next   = cnt_reg + CW'(1);
                    q_vld_next = 1'b1;
                    q_idx_next = ptr_reg;
                end
                if (complete)
                begin
                    state_next = S_RDOUT;
                    unique case (pass_reg)
                        PASS_ALLOC:
                        begin
                            status_next = found_reg ? STAT_OK : STAT_FULL;
                        end
                        PASS_SWITCH:
                        begin
                            status_next = found_reg ? sw_ok_reg : STAT_NONE;
                        end
                        PASS_KILL:
                        begin
                            status_next = found_reg ? STAT_OK : STAT_NOPID;
                        end
                        PASS_WAKE:
                        begin
                            go_pass = (cmd_reg == CMD_EXIT);
                        end
                        PASS_REPAR:
                        begin
                            keya_next = chan_of(newpar_reg);
                            keyb_next = chan_of(init_reg);
                            go_pass   = 1'b1;
                            go_kind   = PASS_WAKE;
                        end
                        default:
                        begin
                            if (!found_reg)
                            begin
                                status_next = STAT_NOCHILD;
                            end
                            else if (!reaped_reg)
                            begin
                                sw_ok_next = STAT_BLOCKED;
                                state_next = S_CURWR;
                            end
                        end
                    endcase
                end
            end
            S_CURWR:
            begin
                // wait with live children but no zombie: sleep on own channel
                tbl_we    = 1'b1;
                waddr     = run_reg;
                wrec      = cur_rec_reg;
                wrec.st   = ST_SLEEPING;
                wrec.chan = chan_of(PW'(run_reg));
                wpar      = cur_par_reg;
                go_pass   = 1'b1;
            end
            S_RDOUT:
            begin
                tbl_re     = 1'b1;
                raddr      = run_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rrun_next      = 6'(run_reg);
                rrun_pid_next  = rd_rec.pid;
                rrun_kill_next = rd_rec.killed;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go_pass)
        begin
            state_next  = S_SCAN;
            pass_next   = go_kind;
            cnt_next    = '0;
            stop_next   = 1'b0;
            found_next  = 1'b0;
            reaped_next = 1'b0;
            q_vld_next  = 1'b0;
            ptr_next    = (go_kind == PASS_SWITCH) ? wrap_inc(run_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pass_reg  <= PASS_SWITCH;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            stop_reg  <= 1'b0;
            q_vld_reg <= 1'b0;
            run_reg   <= '0;
            init_reg  <= NONE;
            ctr_reg   <= 32'd1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            stop_reg  <= stop_next;
            q_vld_reg <= q_vld_next;
            run_reg   <= run_next;
            init_reg  <= init_next;
            ctr_reg   <= ctr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        opnd_reg      <= opnd_next;
        q_idx_reg     <= q_idx_next;
        found_reg     <= found_next;
        reaped_reg    <= reaped_next;
        sw_ok_reg     <= sw_ok_next;
        keya_reg      <= keya_next;
        keyb_reg      <= keyb_next;
        newpar_reg    <= newpar_next;
        cur_rec_reg   <= cur_rec_next;
        cur_par_reg   <= cur_par_next;
        status_reg    <= status_next;
        rslot_reg     <= rslot_next;
        rpid_reg      <= rpid_next;
        rcode_reg     <= rcode_next;
        rrun_reg      <= rrun_next;
        rrun_pid_reg  <= rrun_pid_next;
        rrun_kill_reg <= rrun_kill_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign result_status    = status_reg;
    assign result_slot      = rslot_reg;
    assign result_pid       = rpid_reg;
    assign reaped_exit_code = rcode_reg;
    assign running_slot     = rrun_reg;
    assign running_pid      = rrun_pid_reg;
    assign running_killed   = rrun_kill_reg;

    `PTS_ASSERT(a_done_single, done |=> !done, "done strobe longer than one beat")
    `PTS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "command accepted but not busy")
    `PTS_NEVER(a_cnt_range, cnt_reg > CW'(SLOTS), "scan count past table size")
    `PTS_NEVER(a_rw_clash, tbl_we && tbl_re && (waddr == raddr), "read and write same slot")
    `PTS_ASSERT(a_status_code, done |-> (result_status <= STAT_NONE), "undefined status code")

endmodule
